/* hw/rtl/sorted_list_intersection_unit_defines.svh */
// assertion macros used by the checker file
`ifndef SORTED_LIST_INTERSECTION_UNIT_DEFINES_SVH
`define SORTED_LIST_INTERSECTION_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SLU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SLU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/slu_pkg.sv */
package slu_pkg;

	// key width of every stored and emitted key
	localparam int KEY_W = 31;

	// request operation codes
	typedef enum logic [1:0] {
		OP_APPEND_A  = 2'd0,
		OP_APPEND_B  = 2'd1,
		OP_INTERSECT = 2'd2,
		OP_CLEAR     = 2'd3
	} opcode_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CMP,
		ST_ELOAD,
		ST_ESEND,
		ST_EEMPTY
	} state_t;

endpackage

/* hw/rtl/slu_req_if.sv */
interface slu_req_if;
	import slu_pkg::*;

	logic             valid;
	logic             ready;
	opcode_t          opcode;
	logic [KEY_W-1:0] key_value;

	modport source (output valid, output opcode, output key_value, input ready);
	modport sink (input valid, input opcode, input key_value, output ready);
endinterface

/* hw/rtl/slu_res_if.sv */
interface slu_res_if;
	import slu_pkg::*;

	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] common_key;
	logic             is_last;
	logic             is_empty;
	logic             overflowed;

	modport source (
		output valid, output common_key, output is_last, output is_empty, output overflowed,
		input ready
	);
	modport sink (
		input valid, input common_key, input is_last, input is_empty, input overflowed,
		output ready
	);
endinterface

/* hw/rtl/sorted_list_intersection_unit.sv */
// Sorted list intersection unit.
// Request channel (req): opcode and key_value. Append to list A, append to
// list B, clear both lists, or intersect. Result channel (res): common_key,
// is_last, is_empty, overflowed; one result per common key of a run, or a
// single empty result when nothing matches.
// Appends and clears give no result; an append to a full list is dropped
// and flagged on the next run.
// An intersect walks both lists with one shared compare unit: each step is a
// memory read state (ST_LOAD) followed by a compare state (ST_CMP). The hits
// are written back into list A in place; emission then reads each one back
// in ST_ELOAD and sends it from ST_ESEND. After the run A holds the
// intersection and B is empty.
// req.ready is high only while the sequencer is idle. The last result may
// still sit in the output register while new requests are accepted.
// A stalled receiver holds the sequencer at the emit step; nothing is lost.
// Reset clears both counts, the overflow flag and the output valid flag; list
// memories need no clearing since only written entries are ever read.
module sorted_list_intersection_unit #(
	parameter int MAX_LEN = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	slu_req_if.sink           req,
	slu_res_if.source         res
);
	import slu_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	// list memories
	logic [KEY_W-1:0] mem_a [MAX_LEN];
	logic [KEY_W-1:0] mem_b [MAX_LEN];
	logic [KEY_W-1:0] a_rd_q;
	logic [KEY_W-1:0] b_rd_q;

	state_t           state_q;
	state_t           state_d;
	logic [CW-1:0]    cnt_a_q;
	logic [CW-1:0]    cnt_b_q;
	logic [CW-1:0]    i_q;
	logic [CW-1:0]    j_q;
	logic [CW-1:0]    n_q;
	logic [CW-1:0]    k_q;
	logic             ovf_seen_q;
	logic             run_ovf_q;

	logic             out_valid_q;
	logic [KEY_W-1:0] out_key_q;
	logic             out_last_q;
	logic             out_empty_q;
	logic             out_ovf_q;

	logic             req_acc;
	logic             slot_free;
	logic             keys_eq;
	logic             b_less;
	logic             merge_done;
	logic             k_last;
	logic             a_full;
	logic             b_full;
	logic             out_load;
	logic [KEY_W-1:0] out_key_d;
	logic             out_last_d;
	logic             out_empty_d;

	logic             a_we;
	logic [AW-1:0]    a_waddr;
	logic [KEY_W-1:0] a_wdata;
	logic [AW-1:0]    a_raddr;
	logic             b_we;

	// handshake and compare unit
	assign req.ready  = (state_q == ST_IDLE);
	assign req_acc    = req.valid && req.ready;
	assign slot_free  = !out_valid_q || res.ready;
	assign keys_eq    = (a_rd_q == b_rd_q);
	assign b_less     = (b_rd_q < a_rd_q);
	assign merge_done = (i_q >= cnt_a_q) || (j_q >= cnt_b_q);
	assign k_last     = ((k_q + CW'(1)) == cnt_a_q);
	assign a_full     = (cnt_a_q >= CW'(MAX_LEN));
	assign b_full     = (cnt_b_q >= CW'(MAX_LEN));

	// memory port control, emit states keep reading the pending hit
	assign a_we    = (req_acc && req.opcode == OP_APPEND_A && !a_full)
		|| (state_q == ST_CMP && keys_eq);
	assign a_waddr = (state_q == ST_IDLE) ? cnt_a_q[AW-1:0] : n_q[AW-1:0];
	assign a_wdata = (state_q == ST_IDLE) ? req.key_value : a_rd_q;
	assign a_raddr = (state_q == ST_ELOAD || state_q == ST_ESEND) ? k_q[AW-1:0]
		: i_q[AW-1:0];
	assign b_we    = req_acc && req.opcode == OP_APPEND_B && !b_full;

	always_ff @(posedge clk) begin
		if (a_we) begin
			mem_a[a_waddr] <= a_wdata;
		end
		a_rd_q <= mem_a[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			mem_b[cnt_b_q[AW-1:0]] <= req.key_value;
		end
		b_rd_q <= mem_b[j_q[AW-1:0]];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and result loading
	always_comb begin
		state_d     = state_q;
		out_load    = 1'b0;
		out_key_d   = a_rd_q;
		out_last_d  = k_last;
		out_empty_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc && req.opcode == OP_INTERSECT) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (merge_done) begin
					state_d = (n_q == '0) ? ST_EEMPTY : ST_ELOAD;
				end else begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_LOAD;
			end
			ST_ELOAD: begin
				state_d = ST_ESEND;
			end
			ST_ESEND: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = k_last ? ST_IDLE : ST_ELOAD;
				end
			end
			ST_EEMPTY: begin
				out_key_d   = '0;
				out_last_d  = 1'b1;
				out_empty_d = 1'b1;
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// list counts, merge pointers and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q    <= '0;
			cnt_b_q    <= '0;
			i_q        <= '0;
			j_q        <= '0;
			n_q        <= '0;
			k_q        <= '0;
			ovf_seen_q <= 1'b0;
			run_ovf_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						unique case (req.opcode)
							OP_APPEND_A: begin
								if (a_full) begin
									ovf_seen_q <= 1'b1;
								end else begin
									cnt_a_q <= cnt_a_q + CW'(1);
								end
							end
							OP_APPEND_B: begin
								if (b_full) begin
									ovf_seen_q <= 1'b1;
								end else begin
									cnt_b_q <= cnt_b_q + CW'(1);
								end
							end
							OP_INTERSECT: begin
								i_q        <= '0;
								j_q        <= '0;
								n_q        <= '0;
								run_ovf_q  <= ovf_seen_q;
								ovf_seen_q <= 1'b0;
							end
							OP_CLEAR: begin
								cnt_a_q <= '0;
								cnt_b_q <= '0;
							end
							default: begin
								cnt_a_q <= cnt_a_q;
							end
						endcase
					end
				end
				ST_LOAD: begin
					if (merge_done) begin
						cnt_a_q <= n_q;
						cnt_b_q <= '0;
						k_q     <= '0;
					end
				end
				ST_CMP: begin
					// b below a advances b only; a match advances both and keeps the hit
					if (b_less) begin
						j_q <= j_q + CW'(1);
					end else if (keys_eq) begin
						j_q <= j_q + CW'(1);
						i_q <= i_q + CW'(1);
						n_q <= n_q + CW'(1);
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				ST_ESEND: begin
					if (slot_free) begin
						k_q <= k_q + CW'(1);
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_key_q   <= out_key_d;
			out_last_q  <= out_last_d;
			out_empty_q <= out_empty_d;
			out_ovf_q   <= run_ovf_q;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.common_key = out_key_q;
	assign res.is_last    = out_last_q;
	assign res.is_empty   = out_empty_q;
	assign res.overflowed = out_ovf_q;

endmodule

/* hw/rtl/slu_checker.sv */
`include "sorted_list_intersection_unit_defines.svh"

module slu_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_ready,
	input slu_pkg::opcode_t         req_opcode,
	input logic                     res_valid,
	input logic                     res_ready,
	input logic [slu_pkg::KEY_W-1:0] res_common_key,
	input logic                     res_is_last,
	input logic                     res_is_empty
);
	import slu_pkg::*;

	logic req_acc;

	assign req_acc = req_valid && req_ready;

	// an intersect request makes the block busy
	`SLU_ASSERT_NEXT(a_busy_after_run, req_acc && req_opcode == OP_INTERSECT, !req_ready, "block ready right after an intersect request")

	// the block is ready again in the cycle after an append or clear
	`SLU_ASSERT_NEXT(a_ready_after_update, req_acc && req_opcode != OP_INTERSECT, req_ready, "block not ready after an append or clear")

	// the empty result is a lone final result with a zero key
	`SLU_ASSERT_NOW(a_empty_form, res_valid && res_is_empty, res_is_last && res_common_key == '0, "empty result not last or key not zero")

	// a stalled result holds its key
	`SLU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_common_key), "stalled result changed")

endmodule

bind sorted_list_intersection_unit slu_checker u_slu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_opcode     (req.opcode),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_common_key (res.common_key),
	.res_is_last    (res.is_last),
	.res_is_empty   (res.is_empty)
);

/* test/testbench.sv */
module testbench;
	import slu_pkg::*;

	localparam int LIST_DEPTH = 64;
	localparam int TOTAL_REQUESTS = 430;
	localparam int TAIL_REQUESTS = 60;
	localparam int RESET_CYCLES = 6;
	localparam int SINK_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct {
		opcode_t     op;
		key_t        key;
		bit          drain_first;
		bit          hold_sink;
		int unsigned idle_pct;
	} list_request_t;

	typedef struct {
		key_t key;
		logic last;
		logic empty;
		logic dropped;
	} match_result_t;

	logic clk = 1'b0;
	logic arst_n;

	slu_req_if req();
	slu_res_if res();

	sorted_list_intersection_unit #(.MAX_LEN(LIST_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	always #6 clk = ~clk;

	// requests still to send, matches still to receive
	list_request_t queued_requests[$];
	match_result_t due_matches[$];
	key_t          recent_a_keys[$];
	int unsigned   gen_idle_pct;
	int unsigned   mismatches = 0;

	// shadow copy of the two lists
	key_t        model_a [LIST_DEPTH];
	key_t        model_b [LIST_DEPTH];
	int unsigned len_a = 0;
	int unsigned len_b = 0;
	logic        drop_seen = 1'b0;

	// cross-process control
	logic        hold_trigger;
	logic        tail_phase;
	int unsigned sink_hold_left;

	// update the shadow lists for one accepted request and queue its matches
	task automatic track_list_request(opcode_t op, key_t key);
		key_t        hits [LIST_DEPTH];
		int unsigned hit_count;
		int unsigned j;
		hit_count = 0;
		j = 0;
		case (op)
			OP_APPEND_A: begin
				if (len_a < LIST_DEPTH) begin
					model_a[len_a] = key;
					len_a++;
				end else begin
					drop_seen = 1'b1;
				end
			end
			OP_APPEND_B: begin
				if (len_b < LIST_DEPTH) begin
					model_b[len_b] = key;
					len_b++;
				end else begin
					drop_seen = 1'b1;
				end
			end
			OP_INTERSECT: begin
				// single merge pass, b pointer only moves forward
				for (int unsigned i = 0; i < len_a; i++) begin
					while (j < len_b && model_b[j] < model_a[i])
						j++;
					if (j >= len_b)
						break;
					if (model_b[j] == model_a[i]) begin
						hits[hit_count] = model_a[i];
						hit_count++;
						j++;
					end
				end
				if (hit_count == 0) begin
					due_matches.insert(due_matches.size(),
						'{key: '0, last: 1'b1, empty: 1'b1, dropped: drop_seen});
				end else begin
					for (int unsigned k = 0; k < hit_count; k++) begin
						due_matches.insert(due_matches.size(),
							'{key: hits[k], last: (k + 1 == hit_count),
							empty: 1'b0, dropped: drop_seen});
						model_a[k] = hits[k];
					end
				end
				len_a = hit_count;
				len_b = 0;
				drop_seen = 1'b0;
			end
			OP_CLEAR: begin
				len_a = 0;
				len_b = 0;
			end
		endcase
	endtask

	function automatic key_t random_key();
		return key_t'($urandom());
	endfunction

	// start of an ascending run that fits below the key ceiling
	function automatic key_t pick_base(int unsigned span);
		int unsigned top;
		top = 32'h7FFF_FFFF - span;
		case ($urandom_range(0, 3))
			0: return '0;
			1: return key_t'(top);
			default: return key_t'($urandom_range(0, top));
		endcase
	endfunction

	task automatic add_request(opcode_t op, key_t key);
		queued_requests.insert(queued_requests.size(),
			'{op: op, key: key, drain_first: 1'b0, hold_sink: 1'b0,
			idle_pct: gen_idle_pct});
	endtask

	// ascending keys spread over A only, B only or both
	task automatic add_sorted_lists(int unsigned union_size, int unsigned step_max);
		key_t        key;
		int unsigned pick;
		key = pick_base(union_size * step_max);
		recent_a_keys.delete();
		repeat (union_size) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				add_request(OP_APPEND_A, key);
				recent_a_keys.insert(recent_a_keys.size(), key);
			end
			if (pick < 40 || pick >= 70)
				add_request(OP_APPEND_B, key);
			key += key_t'($urandom_range(1, step_max));
		end
	endtask

	// chain: B gets a subset of the last A keys, then intersect again
	task automatic add_chained_b();
		foreach (recent_a_keys[n]) begin
			if ($urandom_range(0, 1) == 1)
				add_request(OP_APPEND_B, recent_a_keys[n]);
		end
		add_request(OP_INTERSECT, random_key());
	endtask

	// request driver
	bit            offer_next;
	bit            hold_pulse;
	list_request_t sent_req;
	int unsigned   send_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.opcode <= OP_APPEND_A;
			req.key_value <= '0;
			hold_trigger <= 1'b0;
			tail_phase <= 1'b0;
		end else begin
			offer_next = req.valid && !req.ready;
			hold_pulse = 1'b0;
			if (req.valid && req.ready) begin
				sent_req = queued_requests.pop_front();
				track_list_request(sent_req.op, sent_req.key);
				hold_pulse = sent_req.hold_sink;
			end
			if (!offer_next && queued_requests.size() != 0) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (queued_requests[0].drain_first && due_matches.size() != 0) begin
					// pause until every match has arrived
				end else if (!tail_phase && sink_hold_left == 0
						&& $urandom_range(0, 99) < queued_requests[0].idle_pct) begin
					send_gap = $urandom_range(1, 18) - 1;
				end else begin
					offer_next = 1'b1;
				end
			end
			req.valid <= offer_next;
			if (offer_next) begin
				req.opcode <= queued_requests[0].op;
				req.key_value <= queued_requests[0].key;
			end
			hold_trigger <= hold_pulse;
			tail_phase <= (queued_requests.size() < TAIL_REQUESTS);
		end
	end

	task automatic report_field(string name, key_t want, key_t got);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		mismatches++;
	endtask

	// result monitor and receiver stalls
	match_result_t want;
	bit            take_next;
	int unsigned   hold_next;
	int unsigned   sink_gap = 0;
	int unsigned   sink_stall_pct = 0;
	int unsigned   mode_timer = 0;
	int unsigned   stall_choices [4] = '{0, 10, 30, 60};

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			sink_hold_left <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (due_matches.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual key %h last %b empty %b overflow %b",
						$time, res.common_key, res.is_last, res.is_empty, res.overflowed);
					mismatches++;
				end else begin
					want = due_matches.pop_front();
					if (res.common_key !== want.key)
						report_field("common_key", want.key, res.common_key);
					if (res.is_last !== want.last)
						report_field("is_last", key_t'(want.last), key_t'(res.is_last));
					if (res.is_empty !== want.empty)
						report_field("is_empty", key_t'(want.empty), key_t'(res.is_empty));
					if (res.overflowed !== want.dropped)
						report_field("overflowed", key_t'(want.dropped), key_t'(res.overflowed));
				end
			end
			// long hold-off first, then random stall bursts
			hold_next = hold_trigger ? SINK_HOLD_CYCLES : sink_hold_left;
			take_next = 1'b0;
			if (hold_next != 0) begin
				hold_next--;
			end else if (sink_gap != 0) begin
				sink_gap--;
			end else if (!tail_phase && $urandom_range(0, 99) < sink_stall_pct) begin
				sink_gap = $urandom_range(1, 18) - 1;
			end else begin
				take_next = 1'b1;
			end
			if (mode_timer == 0) begin
				sink_stall_pct = stall_choices[$urandom_range(0, 3)];
				mode_timer = 80;
			end else begin
				mode_timer--;
			end
			res.ready <= take_next;
			sink_hold_left <= hold_next;
		end
	end

	// watchdog on cycles without any handshake
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	int unsigned idle_choices [4] = '{0, 10, 25, 50};
	int unsigned step_choices [4] = '{1, 3, 1000, 1 << 20};

	initial begin
		key_t        key;
		int unsigned pick;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.opcode = OP_APPEND_A;
		req.key_value = '0;
		res.ready = 1'b0;

		// directed: empty lists, key extremes, chaining, clear, unordered lists
		gen_idle_pct = 20;
		add_request(OP_INTERSECT, 31'h7FFF_FFFF);
		add_request(OP_APPEND_A, 31'h0000_0000);
		add_request(OP_APPEND_A, 31'h7FFF_FFFF);
		add_request(OP_APPEND_B, 31'h0000_0000);
		add_request(OP_INTERSECT, 31'h0000_0000);
		add_request(OP_APPEND_A, 31'h2AAA_AAAA);
		add_request(OP_APPEND_A, 31'h5555_5555);
		add_request(OP_APPEND_A, 31'h7FFF_FFFF);
		add_request(OP_APPEND_B, 31'h2AAA_AAAA);
		add_request(OP_APPEND_B, 31'h5555_5555);
		add_request(OP_APPEND_B, 31'h7FFF_FFFF);
		add_request(OP_INTERSECT, 31'h5555_5555);
		add_request(OP_APPEND_B, 31'h5555_5555);
		add_request(OP_INTERSECT, 31'h2AAA_AAAA);
		add_request(OP_CLEAR, 31'h2AAA_AAAA);
		add_request(OP_INTERSECT, random_key());
		add_request(OP_APPEND_A, 31'd5);
		add_request(OP_INTERSECT, random_key());
		add_request(OP_APPEND_A, 31'd9);
		add_request(OP_APPEND_A, 31'd3);
		add_request(OP_APPEND_B, 31'd3);
		add_request(OP_APPEND_B, 31'd9);
		add_request(OP_INTERSECT, random_key());

		// full lists: 64 matches, dropped appends on both sides, receiver hold-off
		gen_idle_pct = 0;
		add_request(OP_CLEAR, random_key());
		key = pick_base(66 * 3);
		for (int n = 0; n < 66; n++) begin
			add_request(OP_APPEND_A, key);
			if (n < 65)
				add_request(OP_APPEND_B, key);
			key += key_t'($urandom_range(1, 3));
		end
		add_request(OP_INTERSECT, random_key());
		queued_requests[$].hold_sink = 1'b1;
		// A is full after the run; the flag survives a clear
		add_request(OP_APPEND_A, random_key());
		add_request(OP_APPEND_B, random_key());
		add_request(OP_CLEAR, random_key());
		add_request(OP_INTERSECT, random_key());
		add_request(OP_APPEND_A, random_key());
		queued_requests[$].drain_first = 1'b1;

		// random mix: mostly sorted lists, some noise and unordered lists
		while (queued_requests.size() < TOTAL_REQUESTS) begin
			gen_idle_pct = idle_choices[$urandom_range(0, 3)];
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if ($urandom_range(0, 9) < 7)
					add_request(OP_CLEAR, random_key());
				add_sorted_lists(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12), step_choices[$urandom_range(0, 3)]);
				add_request(OP_INTERSECT, random_key());
				if ($urandom_range(0, 2) == 0)
					add_chained_b();
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 5))
					add_request(opcode_t'($urandom_range(0, 3)), random_key());
			end else begin
				// unordered appends over a tiny key pool, sometimes cut by a clear
				repeat ($urandom_range(1, 8))
					add_request(opcode_t'($urandom_range(0, 1)), key_t'($urandom_range(0, 7)));
				if ($urandom_range(0, 3) == 0)
					add_request(OP_CLEAR, random_key());
				add_request(OP_INTERSECT, random_key());
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (queued_requests.size() != 0 || due_matches.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && due_matches.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
